>>> src/l1_coherence_line_controller_unit_macros.svh
// Assertion macros used by the checker file of the line controller.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef L1_COHERENCE_LINE_CONTROLLER_UNIT_MACROS_SVH
`define L1_COHERENCE_LINE_CONTROLLER_UNIT_MACROS_SVH

// antecedent and consequent checked at the same edge
`define LCC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line controller check failed");

// consequent checked in the cycle after the antecedent
`define LCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line controller check failed");

`endif

>>> src/lcc_pkg.sv
// Shared types and codes of the L1 coherence line controller.
// No dependencies.
package lcc_pkg;

    localparam int QUEUE_DEPTH_DEF  = 2;
    localparam int RESULT_DEPTH_DEF = 2;

    // configuration register indexes
    localparam logic [0:0] CFG_BYPASS = 1'b0;
    localparam logic [0:0] CFG_ICACHE = 1'b1;

    // action codes
    localparam logic [2:0] ACT_REPL = 3'd0;
    localparam logic [2:0] ACT_LD   = 3'd1;
    localparam logic [2:0] ACT_ST   = 3'd2;
    localparam logic [2:0] ACT_DSH  = 3'd3;
    localparam logic [2:0] ACT_DEX  = 3'd4;
    localparam logic [2:0] ACT_UACK = 3'd5;
    localparam logic [2:0] ACT_INV  = 3'd6;
    localparam logic [2:0] ACT_RFWD = 3'd7;

    // line states
    localparam logic [2:0] ST_NP  = 3'd0;
    localparam logic [2:0] ST_I   = 3'd1;
    localparam logic [2:0] ST_ISE = 3'd2;
    localparam logic [2:0] ST_IM  = 3'd3;
    localparam logic [2:0] ST_S   = 3'd4;
    localparam logic [2:0] ST_E   = 3'd5;
    localparam logic [2:0] ST_M   = 3'd6;
    localparam logic [2:0] ST_SM  = 3'd7;

    // stall codes
    localparam logic [1:0] STALL_NONE  = 2'd0;
    localparam logic [1:0] STALL_OTHER = 2'd1;
    localparam logic [1:0] STALL_SET   = 2'd2;

    // messages sent down
    localparam logic [3:0] DN_NONE   = 4'd0;
    localparam logic [3:0] DN_READ   = 4'd1;
    localparam logic [3:0] DN_READEX = 4'd2;
    localparam logic [3:0] DN_UPG    = 4'd3;
    localparam logic [3:0] DN_REPL   = 4'd4;
    localparam logic [3:0] DN_FWD    = 4'd5;
    localparam logic [3:0] DN_INVACK = 4'd6;
    localparam logic [3:0] DN_WBC    = 4'd7;
    localparam logic [3:0] DN_WB     = 4'd8;

    // MSHR commands
    localparam logic [1:0] MSHR_NONE  = 2'd0;
    localparam logic [1:0] MSHR_ALLOC = 2'd1;
    localparam logic [1:0] MSHR_ENQ   = 2'd2;
    localparam logic [1:0] MSHR_DRAIN = 2'd3;

    // event marks
    localparam logic [2:0] EVT_NONE  = 3'd0;
    localparam logic [2:0] EVT_DMISS = 3'd1;
    localparam logic [2:0] EVT_CMISS = 3'd2;
    localparam logic [2:0] EVT_PHIT  = 3'd3;
    localparam logic [2:0] EVT_HIT   = 3'd4;
    localparam logic [2:0] EVT_WB    = 3'd5;
    localparam logic [2:0] EVT_STALL = 3'd6;
    localparam logic [2:0] EVT_BYP   = 3'd7;

    // event kind after thread-state rewriting
    typedef enum logic [3:0] {
        K_REPL,
        K_LD,
        K_ST,
        K_DSH,
        K_DEX,
        K_UACK,
        K_INV,
        K_RFWD,
        K_TLD,
        K_TST,
        K_TRSP
    } kind_t;

    typedef struct packed {
        logic [2:0] action;
        logic [2:0] line_state;
        logic       thread_state;
        logic [1:0] insert_stall;
        logic       mshr_free;
        logic       mshr_queue_room;
        logic       prefetch_req;
    } in_item_t;

    typedef struct packed {
        logic [2:0] new_state;
        logic [1:0] stall_res;
        logic [3:0] down_message;
        logic       queued_readex;
        logic       invalidate_up;
        logic       data_response_up;
        logic [1:0] mshr_command;
        logic       insert_line;
        logic       store_data;
        logic       prefetch_mark;
        logic [2:0] event_mark;
        logic       illegal;
    } out_item_t;

    // classified event handed from front to back
    typedef struct packed {
        kind_t      kind;
        logic [2:0] line_state;
        logic [1:0] alloc_stall;
        logic       mshr_free;
        logic       room;
        logic       pref;
    } cls_item_t;

endpackage

>>> src/lcc_fifo.sv
// Small first-in first-out queue with simultaneous push and pop.
// Depends on nothing; DEPTH must be 2 or more.
module lcc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> src/lcc_front.sv
// Front end: accepts an event, applies thread-state bypass rewriting and
// saturates the allocation check. Uses lcc_pkg.
module lcc_front (
    input  logic              push,
    output logic              full,
    input  lcc_pkg::in_item_t item,
    input  logic              bypass_en,
    input  logic              q_full,
    output logic              q_wr,
    output lcc_pkg::cls_item_t cls
);

    logic tstate;

    assign full   = q_full;
    assign q_wr   = push && !q_full;
    assign tstate = bypass_en && item.thread_state;

    always_comb
    begin
        cls.line_state  = item.line_state;
        // code three counts as a set-event stall
        cls.alloc_stall = (item.insert_stall == 2'd3) ? lcc_pkg::STALL_SET : item.insert_stall;
        cls.mshr_free   = item.mshr_free;
        cls.room        = item.mshr_queue_room;
        cls.pref        = item.prefetch_req;
        case (item.action)
            lcc_pkg::ACT_REPL: cls.kind = lcc_pkg::K_REPL;
            lcc_pkg::ACT_LD:   cls.kind = tstate ? lcc_pkg::K_TLD : lcc_pkg::K_LD;
            lcc_pkg::ACT_ST:   cls.kind = tstate ? lcc_pkg::K_TST : lcc_pkg::K_ST;
            lcc_pkg::ACT_DSH:  cls.kind = tstate ? lcc_pkg::K_TRSP : lcc_pkg::K_DSH;
            lcc_pkg::ACT_DEX:  cls.kind = tstate ? lcc_pkg::K_TRSP : lcc_pkg::K_DEX;
            lcc_pkg::ACT_UACK: cls.kind = lcc_pkg::K_UACK;
            lcc_pkg::ACT_INV:  cls.kind = lcc_pkg::K_INV;
            default:           cls.kind = lcc_pkg::K_RFWD;
        endcase
    end

endmodule

>>> src/lcc_back.sv
// Back end: protocol transition table for one classified event.
// Uses lcc_pkg; feeds the result queue in the top level.
module lcc_back (
    input  logic               q_empty,
    output logic               q_rd,
    input  lcc_pkg::cls_item_t cls,
    input  logic               icache_en,
    input  logic               res_full,
    output logic               res_wr,
    output lcc_pkg::out_item_t res
);

    assign q_rd   = !q_empty && !res_full;
    assign res_wr = q_rd;

    always_comb
    begin
        lcc_pkg::out_item_t r;
        logic               bad;
        logic [1:0]         stall;
        logic               inv_up;
        lcc_pkg::kind_t     k;
        logic [2:0]         cur;

        k      = cls.kind;
        cur    = cls.line_state;
        inv_up = !icache_en;
        r      = '0;
        r.new_state = cur;
        bad    = 1'b0;
        stall  = lcc_pkg::STALL_NONE;

        case (cur)
            lcc_pkg::ST_NP,
            lcc_pkg::ST_I:
            begin
                if (k == lcc_pkg::K_LD || k == lcc_pkg::K_ST)
                begin
                    if (cur == lcc_pkg::ST_NP && cls.alloc_stall != lcc_pkg::STALL_NONE)
                    begin
                        stall = cls.alloc_stall;
                    end
                    else if (!cls.mshr_free || !cls.room)
                    begin
                        stall = lcc_pkg::STALL_OTHER;
                    end
                    else
                    begin
                        r.insert_line   = 1'b1;
                        r.mshr_command  = lcc_pkg::MSHR_ALLOC;
                        r.down_message  = (k == lcc_pkg::K_LD) ? lcc_pkg::DN_READ
                                                               : lcc_pkg::DN_READEX;
                        r.new_state     = (k == lcc_pkg::K_LD) ? lcc_pkg::ST_ISE
                                                               : lcc_pkg::ST_IM;
                        r.event_mark    = lcc_pkg::EVT_DMISS;
                        r.prefetch_mark = cls.pref;
                    end
                end
                else if (k == lcc_pkg::K_INV)
                begin
                    r.invalidate_up = inv_up;
                end
                else if (k == lcc_pkg::K_RFWD)
                begin
                    r.new_state = cur;
                end
                else if (cur == lcc_pkg::ST_NP && k == lcc_pkg::K_TLD)
                begin
                    r.event_mark   = lcc_pkg::EVT_DMISS;
                    r.down_message = lcc_pkg::DN_READ;
                end
                else if (cur == lcc_pkg::ST_NP && k == lcc_pkg::K_TST)
                begin
                    r.event_mark   = lcc_pkg::EVT_DMISS;
                    r.down_message = lcc_pkg::DN_READEX;
                end
                else if (cur == lcc_pkg::ST_NP && k == lcc_pkg::K_TRSP)
                begin
                    r.event_mark       = lcc_pkg::EVT_BYP;
                    r.data_response_up = 1'b1;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            lcc_pkg::ST_IM:
            begin
                if (k == lcc_pkg::K_DEX)
                begin
                    r.store_data   = 1'b1;
                    r.mshr_command = lcc_pkg::MSHR_DRAIN;
                    r.new_state    = lcc_pkg::ST_M;
                end
                else if (k == lcc_pkg::K_RFWD)
                begin
                    r.new_state = cur;
                end
                else if (k == lcc_pkg::K_INV)
                begin
                    r.invalidate_up = inv_up;
                end
                else if (k == lcc_pkg::K_LD || k == lcc_pkg::K_ST)
                begin
                    if (!cls.room)
                    begin
                        stall = lcc_pkg::STALL_OTHER;
                    end
                    else
                    begin
                        r.mshr_command = lcc_pkg::MSHR_ENQ;
                        r.event_mark   = lcc_pkg::EVT_PHIT;
                    end
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            lcc_pkg::ST_ISE:
            begin
                if (k == lcc_pkg::K_DSH || k == lcc_pkg::K_DEX)
                begin
                    r.store_data   = 1'b1;
                    r.mshr_command = lcc_pkg::MSHR_DRAIN;
                    r.new_state    = (k == lcc_pkg::K_DSH) ? lcc_pkg::ST_S : lcc_pkg::ST_E;
                end
                else if (k == lcc_pkg::K_RFWD)
                begin
                    r.new_state = cur;
                end
                else if (k == lcc_pkg::K_INV)
                begin
                    r.invalidate_up = inv_up;
                end
                else if (k == lcc_pkg::K_LD)
                begin
                    if (!cls.room)
                    begin
                        stall = lcc_pkg::STALL_OTHER;
                    end
                    else
                    begin
                        r.mshr_command = lcc_pkg::MSHR_ENQ;
                        r.event_mark   = lcc_pkg::EVT_PHIT;
                    end
                end
                else if (k == lcc_pkg::K_ST)
                begin
                    stall = lcc_pkg::STALL_SET;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            lcc_pkg::ST_S:
            begin
                if (k == lcc_pkg::K_LD)
                begin
                    r.data_response_up = 1'b1;
                    r.event_mark       = lcc_pkg::EVT_HIT;
                end
                else if (k == lcc_pkg::K_ST)
                begin
                    if (!cls.mshr_free || !cls.room)
                    begin
                        stall = lcc_pkg::STALL_OTHER;
                    end
                    else
                    begin
                        r.mshr_command  = lcc_pkg::MSHR_ALLOC;
                        r.down_message  = lcc_pkg::DN_UPG;
                        r.new_state     = lcc_pkg::ST_SM;
                        r.event_mark    = lcc_pkg::EVT_CMISS;
                        r.prefetch_mark = cls.pref;
                    end
                end
                else if (k == lcc_pkg::K_REPL)
                begin
                    r.down_message = lcc_pkg::DN_REPL;
                    r.event_mark   = lcc_pkg::EVT_WB;
                    r.new_state    = lcc_pkg::ST_I;
                end
                else if (k == lcc_pkg::K_RFWD)
                begin
                    r.down_message = lcc_pkg::DN_FWD;
                end
                else if (k == lcc_pkg::K_INV)
                begin
                    r.down_message  = lcc_pkg::DN_INVACK;
                    r.invalidate_up = inv_up;
                    r.new_state     = lcc_pkg::ST_I;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            lcc_pkg::ST_E,
            lcc_pkg::ST_M:
            begin
                if (k == lcc_pkg::K_LD)
                begin
                    r.data_response_up = 1'b1;
                    r.event_mark       = lcc_pkg::EVT_HIT;
                end
                else if (k == lcc_pkg::K_ST)
                begin
                    r.data_response_up = 1'b1;
                    r.event_mark       = lcc_pkg::EVT_HIT;
                    if (cur == lcc_pkg::ST_E)
                    begin
                        r.store_data = 1'b1;
                        r.new_state  = lcc_pkg::ST_M;
                    end
                end
                else if (k == lcc_pkg::K_REPL)
                begin
                    r.down_message = (cur == lcc_pkg::ST_E) ? lcc_pkg::DN_WBC : lcc_pkg::DN_WB;
                    r.event_mark   = lcc_pkg::EVT_WB;
                    r.new_state    = lcc_pkg::ST_I;
                end
                else if (k == lcc_pkg::K_INV)
                begin
                    r.invalidate_up = inv_up;
                    r.down_message  = (cur == lcc_pkg::ST_E) ? lcc_pkg::DN_WBC : lcc_pkg::DN_WB;
                    r.new_state     = lcc_pkg::ST_I;
                end
                else if (k == lcc_pkg::K_RFWD)
                begin
                    r.down_message = lcc_pkg::DN_FWD;
                    r.new_state    = lcc_pkg::ST_S;
                end
                else if (cur == lcc_pkg::ST_E)
                begin
                    bad = 1'b1;
                end
            end
            default:
            begin
                // shared-to-modified, waiting for the upgrade ack
                if (k == lcc_pkg::K_LD)
                begin
                    r.data_response_up = 1'b1;
                    r.event_mark       = lcc_pkg::EVT_HIT;
                end
                else if (k == lcc_pkg::K_ST)
                begin
                    if (!cls.room)
                    begin
                        stall = lcc_pkg::STALL_SET;
                    end
                    else
                    begin
                        r.mshr_command = lcc_pkg::MSHR_ENQ;
                        r.event_mark   = lcc_pkg::EVT_PHIT;
                    end
                end
                else if (k == lcc_pkg::K_UACK)
                begin
                    r.new_state    = lcc_pkg::ST_M;
                    r.mshr_command = lcc_pkg::MSHR_DRAIN;
                end
                else if (k == lcc_pkg::K_INV)
                begin
                    r.new_state     = lcc_pkg::ST_IM;
                    r.down_message  = lcc_pkg::DN_INVACK;
                    r.queued_readex = 1'b1;
                end
                else if (k == lcc_pkg::K_RFWD)
                begin
                    r.down_message = lcc_pkg::DN_FWD;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
        endcase

        // illegal and stalled events leave the line untouched
        if (bad || stall != lcc_pkg::STALL_NONE)
        begin
            r           = '0;
            r.new_state = cur;
            if (bad)
            begin
                r.illegal = 1'b1;
            end
            else
            begin
                r.stall_res  = stall;
                r.event_mark = lcc_pkg::EVT_STALL;
            end
        end

        res = r;
    end

endmodule

>>> src/l1_coherence_line_controller_unit.sv
// Top level of the L1 coherence line controller: config registers, front end,
// event queue, transition back end and result queue. Uses lcc_pkg.
//
//   channel   handshake                 payload
//   -------   -----------------------   ------------------------------
//   events    push / full               item   (lcc_pkg::in_item_t)
//   results   pop / empty               result (lcc_pkg::out_item_t)
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One event per cycle sustained while results are popped; each event yields exactly one result.
// An accepted event is registered in the event queue, looked up by the back end
// at the queue head and registered into the result queue, which drives result.
// The event queue and result queue decouple the sides; full rises only when
// the event queue holds QUEUE_DEPTH entries behind a stalled result queue.
// Reset is asynchronous; both queues come up empty and config bits read 0.
module l1_coherence_line_controller_unit #(
    parameter int QUEUE_DEPTH  = lcc_pkg::QUEUE_DEPTH_DEF,
    parameter int RESULT_DEPTH = lcc_pkg::RESULT_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  lcc_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output lcc_pkg::out_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic               cfg_data
);

    logic               bypass_reg, bypass_next;
    logic               icache_reg, icache_next;
    logic               q_full, q_wr, q_empty, q_rd;
    logic               res_full, res_wr;
    lcc_pkg::cls_item_t cls_in, cls_out;
    lcc_pkg::out_item_t res_in;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        bypass_next = bypass_reg;
        icache_next = icache_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                lcc_pkg::CFG_BYPASS: bypass_next = cfg_data;
                lcc_pkg::CFG_ICACHE: icache_next = cfg_data;
                default:             bypass_next = bypass_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg <= 1'b0;
            icache_reg <= 1'b0;
        end
        else
        begin
            bypass_reg <= bypass_next;
            icache_reg <= icache_next;
        end
    end

    lcc_front u_front (
        .push      (push),
        .full      (full),
        .item      (item),
        .bypass_en (bypass_reg),
        .q_full    (q_full),
        .q_wr      (q_wr),
        .cls       (cls_in)
    );

    lcc_fifo #(
        .WIDTH ($bits(lcc_pkg::cls_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_evt_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (cls_in),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (cls_out),
        .empty   (q_empty)
    );

    lcc_back u_back (
        .q_empty   (q_empty),
        .q_rd      (q_rd),
        .cls       (cls_out),
        .icache_en (icache_reg),
        .res_full  (res_full),
        .res_wr    (res_wr),
        .res       (res_in)
    );

    lcc_fifo #(
        .WIDTH ($bits(lcc_pkg::out_item_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

>>> src/lcc_checker.sv
// Port-level checks for the L1 coherence line controller, bound to the top.
// Uses lcc_pkg and the assertion macros header.
`include "l1_coherence_line_controller_unit_macros.svh"

module lcc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input lcc_pkg::out_item_t result
);

    // a stalled event carries nothing but the stall mark
    `LCC_ASSERT_SAME(a_stall_clean, !empty && result.stall_res != lcc_pkg::STALL_NONE, result.event_mark == lcc_pkg::EVT_STALL && result.down_message == lcc_pkg::DN_NONE && result.mshr_command == lcc_pkg::MSHR_NONE && !result.illegal)

    // an illegal event produces no action
    `LCC_ASSERT_SAME(a_illegal_clean, !empty && result.illegal, result.stall_res == lcc_pkg::STALL_NONE && result.event_mark == lcc_pkg::EVT_NONE && result.down_message == lcc_pkg::DN_NONE && !result.invalidate_up)

    // drained MSHR sends the responses, not this transaction
    `LCC_ASSERT_SAME(a_drain_no_resp, !empty && result.mshr_command == lcc_pkg::MSHR_DRAIN, !result.data_response_up && !result.insert_line)

    // an unread result stays put
    `LCC_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(result))

endmodule

bind l1_coherence_line_controller_unit lcc_checker u_lcc_checker (.*);

>>> sim/l1_coherence_line_controller_unit_tb.sv
// Self-checking testbench of the L1 coherence line controller: directed and
// random events, each result checked against a transition table kept here.
// Depends on lcc_pkg and l1_coherence_line_controller_unit.
module l1_coherence_line_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    lcc_pkg::in_item_t  event_item = '0;
    logic               empty;
    logic               pop = 1'b0;
    lcc_pkg::out_item_t line_result;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [0:0]         cfg_index = '0;
    logic               cfg_data = 1'b0;

    // register copies used when predicting
    logic bypass_on = 1'b0;
    logic icache_on = 1'b0;

    lcc_pkg::out_item_t pending_results[$];
    logic [2:0]         line_walk = lcc_pkg::ST_NP;
    int                 send_idle_pct = 0;
    int                 pop_stall_pct = 0;
    int                 mismatch_count = 0;
    int                 quiet_cycles = 0;

    l1_coherence_line_controller_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (event_item),
        .empty     (empty),
        .pop       (pop),
        .result    (line_result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Next-state table of one line for one event.
    function automatic lcc_pkg::out_item_t predict_transition(lcc_pkg::in_item_t ev,
                                                              logic byp, logic icache);
        lcc_pkg::out_item_t r;
        lcc_pkg::kind_t     evt_kind;
        logic [2:0]         cur;
        logic [1:0]         alloc;
        logic [1:0]         stall;
        logic               inv_up;
        logic               bad;
        cur = ev.line_state;
        r = '0;
        r.new_state = cur;
        bad = 1'b0;
        inv_up = !icache;
        alloc = (ev.insert_stall == 2'd3) ? lcc_pkg::STALL_SET : ev.insert_stall;
        evt_kind = lcc_pkg::kind_t'({1'b0, ev.action});
        if (byp && ev.thread_state)
        begin
            case (evt_kind)
                lcc_pkg::K_LD:                evt_kind = lcc_pkg::K_TLD;
                lcc_pkg::K_ST:                evt_kind = lcc_pkg::K_TST;
                lcc_pkg::K_DSH, lcc_pkg::K_DEX: evt_kind = lcc_pkg::K_TRSP;
                default:                      ;
            endcase
        end

        case (cur)
            lcc_pkg::ST_NP, lcc_pkg::ST_I:
            begin
                case (evt_kind)
                    lcc_pkg::K_LD, lcc_pkg::K_ST:
                    begin
                        if (cur == lcc_pkg::ST_NP && alloc != lcc_pkg::STALL_NONE)
                            r.stall_res = alloc;
                        else if (!ev.mshr_free || !ev.mshr_queue_room)
                            r.stall_res = lcc_pkg::STALL_OTHER;
                        else
                        begin
                            r.insert_line = 1'b1;
                            r.mshr_command = lcc_pkg::MSHR_ALLOC;
                            r.down_message = (evt_kind == lcc_pkg::K_LD) ? lcc_pkg::DN_READ
                                                                         : lcc_pkg::DN_READEX;
                            r.new_state = (evt_kind == lcc_pkg::K_LD) ? lcc_pkg::ST_ISE
                                                                      : lcc_pkg::ST_IM;
                            r.event_mark = lcc_pkg::EVT_DMISS;
                            r.prefetch_mark = ev.prefetch_req;
                        end
                    end
                    lcc_pkg::K_INV:  r.invalidate_up = inv_up;
                    lcc_pkg::K_RFWD: ;
                    lcc_pkg::K_TLD:
                    begin
                        if (cur == lcc_pkg::ST_NP)
                        begin
                            r.event_mark = lcc_pkg::EVT_DMISS;
                            r.down_message = lcc_pkg::DN_READ;
                        end
                        else
                            bad = 1'b1;
                    end
                    lcc_pkg::K_TST:
                    begin
                        if (cur == lcc_pkg::ST_NP)
                        begin
                            r.event_mark = lcc_pkg::EVT_DMISS;
                            r.down_message = lcc_pkg::DN_READEX;
                        end
                        else
                            bad = 1'b1;
                    end
                    lcc_pkg::K_TRSP:
                    begin
                        if (cur == lcc_pkg::ST_NP)
                        begin
                            r.event_mark = lcc_pkg::EVT_BYP;
                            r.data_response_up = 1'b1;
                        end
                        else
                            bad = 1'b1;
                    end
                    default: bad = 1'b1;
                endcase
            end
            lcc_pkg::ST_IM:
            begin
                case (evt_kind)
                    lcc_pkg::K_DEX:
                    begin
                        r.store_data = 1'b1;
                        r.mshr_command = lcc_pkg::MSHR_DRAIN;
                        r.new_state = lcc_pkg::ST_M;
                    end
                    lcc_pkg::K_RFWD: ;
                    lcc_pkg::K_INV:  r.invalidate_up = inv_up;
                    lcc_pkg::K_LD, lcc_pkg::K_ST:
                    begin
                        if (!ev.mshr_queue_room)
                            r.stall_res = lcc_pkg::STALL_OTHER;
                        else
                        begin
                            r.mshr_command = lcc_pkg::MSHR_ENQ;
                            r.event_mark = lcc_pkg::EVT_PHIT;
                        end
                    end
                    default: bad = 1'b1;
                endcase
            end
            lcc_pkg::ST_ISE:
            begin
                case (evt_kind)
                    lcc_pkg::K_DSH, lcc_pkg::K_DEX:
                    begin
                        r.store_data = 1'b1;
                        r.mshr_command = lcc_pkg::MSHR_DRAIN;
                        r.new_state = (evt_kind == lcc_pkg::K_DSH) ? lcc_pkg::ST_S
                                                                   : lcc_pkg::ST_E;
                    end
                    lcc_pkg::K_RFWD: ;
                    lcc_pkg::K_INV:  r.invalidate_up = inv_up;
                    lcc_pkg::K_LD:
                    begin
                        if (!ev.mshr_queue_room)
                            r.stall_res = lcc_pkg::STALL_OTHER;
                        else
                        begin
                            r.mshr_command = lcc_pkg::MSHR_ENQ;
                            r.event_mark = lcc_pkg::EVT_PHIT;
                        end
                    end
                    lcc_pkg::K_ST: r.stall_res = lcc_pkg::STALL_SET;
                    default:       bad = 1'b1;
                endcase
            end
            lcc_pkg::ST_S:
            begin
                case (evt_kind)
                    lcc_pkg::K_LD:
                    begin
                        r.data_response_up = 1'b1;
                        r.event_mark = lcc_pkg::EVT_HIT;
                    end
                    lcc_pkg::K_ST:
                    begin
                        if (!ev.mshr_free || !ev.mshr_queue_room)
                            r.stall_res = lcc_pkg::STALL_OTHER;
                        else
                        begin
                            r.mshr_command = lcc_pkg::MSHR_ALLOC;
                            r.down_message = lcc_pkg::DN_UPG;
                            r.new_state = lcc_pkg::ST_SM;
                            r.event_mark = lcc_pkg::EVT_CMISS;
                            r.prefetch_mark = ev.prefetch_req;
                        end
                    end
                    lcc_pkg::K_REPL:
                    begin
                        r.down_message = lcc_pkg::DN_REPL;
                        r.event_mark = lcc_pkg::EVT_WB;
                        r.new_state = lcc_pkg::ST_I;
                    end
                    lcc_pkg::K_RFWD: r.down_message = lcc_pkg::DN_FWD;
                    lcc_pkg::K_INV:
                    begin
                        r.down_message = lcc_pkg::DN_INVACK;
                        r.invalidate_up = inv_up;
                        r.new_state = lcc_pkg::ST_I;
                    end
                    default: bad = 1'b1;
                endcase
            end
            lcc_pkg::ST_E, lcc_pkg::ST_M:
            begin
                case (evt_kind)
                    lcc_pkg::K_LD:
                    begin
                        r.data_response_up = 1'b1;
                        r.event_mark = lcc_pkg::EVT_HIT;
                    end
                    lcc_pkg::K_ST:
                    begin
                        r.data_response_up = 1'b1;
                        r.event_mark = lcc_pkg::EVT_HIT;
                        if (cur == lcc_pkg::ST_E)
                        begin
                            r.store_data = 1'b1;
                            r.new_state = lcc_pkg::ST_M;
                        end
                    end
                    lcc_pkg::K_REPL:
                    begin
                        r.down_message = (cur == lcc_pkg::ST_E) ? lcc_pkg::DN_WBC
                                                                : lcc_pkg::DN_WB;
                        r.event_mark = lcc_pkg::EVT_WB;
                        r.new_state = lcc_pkg::ST_I;
                    end
                    lcc_pkg::K_INV:
                    begin
                        r.invalidate_up = inv_up;
                        r.down_message = (cur == lcc_pkg::ST_E) ? lcc_pkg::DN_WBC
                                                                : lcc_pkg::DN_WB;
                        r.new_state = lcc_pkg::ST_I;
                    end
                    lcc_pkg::K_RFWD:
                    begin
                        r.down_message = lcc_pkg::DN_FWD;
                        r.new_state = lcc_pkg::ST_S;
                    end
                    // modified silently drops anything else
                    default: bad = (cur == lcc_pkg::ST_E);
                endcase
            end
            default: // shared-to-modified
            begin
                case (evt_kind)
                    lcc_pkg::K_LD:
                    begin
                        r.data_response_up = 1'b1;
                        r.event_mark = lcc_pkg::EVT_HIT;
                    end
                    lcc_pkg::K_ST:
                    begin
                        if (!ev.mshr_queue_room)
                            r.stall_res = lcc_pkg::STALL_SET;
                        else
                        begin
                            r.mshr_command = lcc_pkg::MSHR_ENQ;
                            r.event_mark = lcc_pkg::EVT_PHIT;
                        end
                    end
                    lcc_pkg::K_UACK:
                    begin
                        r.new_state = lcc_pkg::ST_M;
                        r.mshr_command = lcc_pkg::MSHR_DRAIN;
                    end
                    lcc_pkg::K_INV:
                    begin
                        r.new_state = lcc_pkg::ST_IM;
                        r.down_message = lcc_pkg::DN_INVACK;
                        r.queued_readex = 1'b1;
                    end
                    lcc_pkg::K_RFWD: r.down_message = lcc_pkg::DN_FWD;
                    default:         bad = 1'b1;
                endcase
            end
        endcase

        if (bad)
        begin
            r = '0;
            r.new_state = cur;
            r.illegal = 1'b1;
        end
        else if (r.stall_res != lcc_pkg::STALL_NONE)
        begin
            stall = r.stall_res;
            r = '0;
            r.new_state = cur;
            r.stall_res = stall;
            r.event_mark = lcc_pkg::EVT_STALL;
        end
        return r;
    endfunction

    function automatic lcc_pkg::in_item_t make_event(logic [2:0] act, logic [2:0] state,
                                                     logic ts, logic [1:0] ins,
                                                     logic mfree, logic room, logic pref);
        lcc_pkg::in_item_t ev;
        ev.action = act;
        ev.line_state = state;
        ev.thread_state = ts;
        ev.insert_stall = ins;
        ev.mshr_free = mfree;
        ev.mshr_queue_room = room;
        ev.prefetch_req = pref;
        return ev;
    endfunction

    // Mostly coherent walks of one line with realistic resources; some raw noise.
    function automatic lcc_pkg::in_item_t random_event();
        lcc_pkg::in_item_t ev;
        if ($urandom_range(99) < 10)
            return lcc_pkg::in_item_t'(12'($urandom_range(4095)));
        ev.action = 3'($urandom_range(7));
        ev.line_state = ($urandom_range(99) < 60) ? line_walk : 3'($urandom_range(7));
        ev.thread_state = 1'($urandom_range(1));
        ev.insert_stall = ($urandom_range(99) < 75) ? 2'd0 : 2'($urandom_range(3, 1));
        ev.mshr_free = ($urandom_range(99) < 85);
        ev.mshr_queue_room = ($urandom_range(99) < 85);
        ev.prefetch_req = 1'($urandom_range(1));
        return ev;
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_event(lcc_pkg::in_item_t ev);
        lcc_pkg::out_item_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        event_item <= ev;
        do
            @(posedge clk);
        while (full);
        want = predict_transition(ev, bypass_on, icache_on);
        pending_results.push_back(want);
        line_walk = want.new_state;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // the path runs through the event queue and the result queue; give it slack
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [0:0] idx, logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == lcc_pkg::CFG_BYPASS)
            bypass_on = val;
        else
            icache_on = val;
    endtask

    task automatic set_mode(logic byp, logic icache, int gap_pct, int stall_pct);
        wait_drained();
        write_register(lcc_pkg::CFG_BYPASS, byp);
        write_register(lcc_pkg::CFG_ICACHE, icache);
        cfg_valid <= 1'b0;
        send_idle_pct = gap_pct;
        pop_stall_pct = stall_pct;
    endtask

    task automatic run_random_events(int count);
        repeat (count) send_event(random_event());
    endtask

    // Base protocol with bypass off and invalidations passed up.
    task automatic test_base_transitions();
        set_mode(1'b0, 1'b0, 0, 0);
        send_event(make_event(lcc_pkg::ACT_LD, lcc_pkg::ST_NP, 1'b0, 2'd0, 1'b1, 1'b1, 1'b1));
        send_event(make_event(lcc_pkg::ACT_ST, lcc_pkg::ST_I, 1'b0, 2'd0, 1'b1, 1'b1, 1'b0));
        send_event(make_event(lcc_pkg::ACT_LD, lcc_pkg::ST_NP, 1'b0, 2'd1, 1'b1, 1'b1, 1'b0));
        send_event(make_event(lcc_pkg::ACT_ST, lcc_pkg::ST_NP, 1'b0, 2'd2, 1'b1, 1'b1, 1'b0));
        send_event(make_event(lcc_pkg::ACT_LD, lcc_pkg::ST_NP, 1'b0, 2'd3, 1'b1, 1'b1, 1'b0));
        send_event(make_event(lcc_pkg::ACT_LD, lcc_pkg::ST_I, 1'b0, 2'd0, 1'b0, 1'b1, 1'b0));
        send_event(make_event(lcc_pkg::ACT_RFWD, lcc_pkg::ST_NP, 1'b0, 2'd0, 1'b1, 1'b1, 1'b0));
        send_event(make_event(lcc_pkg::ACT_INV, lcc_pkg::ST_I, 1'b0, 2'd0, 1'b1, 1'b1, 1'b0));
        send_event(make_event(lcc_pkg::ACT_DSH, lcc_pkg::ST_ISE, 1'b0, 2'd0, 1'b1, 1'b1, 1'b0));
        send_event(make_event(lcc_pkg::ACT_ST, lcc_pkg::ST_ISE, 1'b0, 2'd0, 1'b1, 1'b1, 1'b0));
        send_event(make_event(lcc_pkg::ACT_DEX, lcc_pkg::ST_IM, 1'b0, 2'd0, 1'b1, 1'b1, 1'b0));
        send_event(make_event(lcc_pkg::ACT_LD, lcc_pkg::ST_IM, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0));
        send_event(make_event(lcc_pkg::ACT_ST, lcc_pkg::ST_S, 1'b0, 2'd0, 1'b1, 1'b1, 1'b1));
        send_event(make_event(lcc_pkg::ACT_INV, lcc_pkg::ST_S, 1'b0, 2'd0, 1'b1, 1'b1, 1'b0));
        send_event(make_event(lcc_pkg::ACT_REPL, lcc_pkg::ST_M, 1'b0, 2'd0, 1'b1, 1'b1, 1'b0));
        send_event(make_event(lcc_pkg::ACT_RFWD, lcc_pkg::ST_E, 1'b0, 2'd0, 1'b1, 1'b1, 1'b0));
        send_event(make_event(lcc_pkg::ACT_UACK, lcc_pkg::ST_M, 1'b0, 2'd0, 1'b1, 1'b1, 1'b0));
        send_event(make_event(lcc_pkg::ACT_UACK, lcc_pkg::ST_SM, 1'b0, 2'd0, 1'b1, 1'b1, 1'b0));
        send_event(make_event(lcc_pkg::ACT_INV, lcc_pkg::ST_SM, 1'b0, 2'd0, 1'b1, 1'b1, 1'b0));
        send_event(make_event(lcc_pkg::ACT_DSH, lcc_pkg::ST_S, 1'b0, 2'd0, 1'b1, 1'b1, 1'b0));
        // all-zero and all-ones items
        send_event('0);
        send_event(make_event(lcc_pkg::ACT_RFWD, lcc_pkg::ST_SM, 1'b1, 2'd3, 1'b1, 1'b1, 1'b1));
    endtask

    // Thread-state rewriting plus suppressed invalidations for an icache.
    task automatic test_thread_state_bypass();
        set_mode(1'b1, 1'b1, 0, 0);
        send_event(make_event(lcc_pkg::ACT_LD, lcc_pkg::ST_NP, 1'b1, 2'd2, 1'b0, 1'b0, 1'b0));
        send_event(make_event(lcc_pkg::ACT_ST, lcc_pkg::ST_NP, 1'b1, 2'd0, 1'b1, 1'b1, 1'b1));
        send_event(make_event(lcc_pkg::ACT_DSH, lcc_pkg::ST_NP, 1'b1, 2'd0, 1'b1, 1'b1, 1'b0));
        send_event(make_event(lcc_pkg::ACT_DEX, lcc_pkg::ST_I, 1'b1, 2'd0, 1'b1, 1'b1, 1'b0));
        send_event(make_event(lcc_pkg::ACT_LD, lcc_pkg::ST_M, 1'b1, 2'd0, 1'b1, 1'b1, 1'b0));
        send_event(make_event(lcc_pkg::ACT_INV, lcc_pkg::ST_E, 1'b0, 2'd0, 1'b1, 1'b1, 1'b0));
        send_event(make_event(lcc_pkg::ACT_ST, lcc_pkg::ST_SM, 1'b1, 2'd0, 1'b1, 1'b1, 1'b0));
        send_event(make_event(lcc_pkg::ACT_INV, lcc_pkg::ST_NP, 1'b1, 2'd0, 1'b1, 1'b1, 1'b0));
    endtask

    task automatic test_random_back_to_back();
        set_mode(1'b0, 1'b0, 0, 0);
        run_random_events(140);
    endtask

    task automatic test_random_sender_gaps();
        set_mode(1'b1, 1'b0, 71, 0);
        run_random_events(140);
    endtask

    task automatic test_random_receiver_stalls();
        set_mode(1'b0, 1'b1, 0, 71);
        run_random_events(140);
    endtask

    task automatic test_random_both_idle();
        set_mode(1'b1, 1'b1, 21, 21);
        run_random_events(130);
    endtask

    // Result checker, pop driver and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;

            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transaction with nothing pending");
                    mismatch_count++;
                end
                else
                begin
                    lcc_pkg::out_item_t want;
                    want = pending_results.pop_front();
                    compare_field("new_state", want.new_state, line_result.new_state);
                    compare_field("stall_res", want.stall_res, line_result.stall_res);
                    compare_field("down_message", want.down_message, line_result.down_message);
                    compare_field("queued_readex", want.queued_readex,
                                  line_result.queued_readex);
                    compare_field("invalidate_up", want.invalidate_up,
                                  line_result.invalidate_up);
                    compare_field("data_response_up", want.data_response_up,
                                  line_result.data_response_up);
                    compare_field("mshr_command", want.mshr_command, line_result.mshr_command);
                    compare_field("insert_line", want.insert_line, line_result.insert_line);
                    compare_field("store_data", want.store_data, line_result.store_data);
                    compare_field("prefetch_mark", want.prefetch_mark,
                                  line_result.prefetch_mark);
                    compare_field("event_mark", want.event_mark, line_result.event_mark);
                    compare_field("illegal", want.illegal, line_result.illegal);
                end
            end

            pop <= ($urandom_range(99) >= pop_stall_pct);

            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("l1_coherence_line_controller_unit: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_base_transitions();
        test_thread_state_bypass();
        test_random_back_to_back();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_both_idle();
        wait_drained();

        if (mismatch_count == 0)
            $display("l1_coherence_line_controller_unit: match");
        else
            $display("l1_coherence_line_controller_unit: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/lcc_pkg.sv
src/lcc_fifo.sv
src/lcc_front.sv
src/lcc_back.sv
src/l1_coherence_line_controller_unit.sv
src/lcc_checker.sv
sim/l1_coherence_line_controller_unit_tb.sv
